>>> rtl/hsps_pkg.sv
// Package for the H.264 SPS resolution parser: result status codes and sizes.
// No dependencies; used by the bit parser and the top level.
package hsps_pkg;

   localparam int unsigned STATUS_W = 3;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_PREFIX    = 3'd1,
      ST_NOT_SPS   = 3'd2,
      ST_BAD_POC   = 3'd3,
      ST_TRUNCATED = 3'd4
   } status_type;

   // Status the bit parser hands to the top level.
   typedef struct packed {
      logic       done;
      logic       failed;
      logic [7:0] sps_id;
      logic [12:0] mb_columns;
      logic [12:0] mb_rows;
   } parse_result_type;

endpackage

>>> rtl/h264_sps_resolution_parser.sv
// Top level of the H.264 SPS resolution parser: byte handshake, prefix check
// and result register. Depends on hsps_pkg and hsps_bit_parser.
// Timing: a prefix byte is handled in the cycle it is accepted; a payload
// byte is accepted in S_BITS, then shifted one bit per cycle into the
// bit-serial parser in S_SHIFT, and only then is the next request taken. A
// last byte passes to S_RESP, which loads the response register, waiting
// only while the response is stalled. The one-bit field unit sets the pace.
// Reset (synchronous, active high) returns the parser to expect a new SPS.
module h264_sps_resolution_parser #(
   parameter int unsigned MAX_MB_DIM    = 4096,
   parameter int unsigned POC_CYCLE_MAX = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata    // [2:0] status, [10:3] sps_id,
                                    // [27:11] pic_width, [44:28] pic_height
);
   import hsps_pkg::*;

   // Prefix states, then BITS accepts a payload byte, SHIFT feeds it to the bit parser and RESP loads the response.
   typedef enum logic [2:0] {
      S_START, S_ZERO1, S_ZERO2, S_ZERO3, S_NAL, S_BITS, S_SHIFT, S_RESP
   } state_type;

   state_type           state_ff;
   logic [7:0]          shreg_ff;
   logic [2:0]          bitcnt_ff;
   logic                last_ff;
   logic [STATUS_W-1:0] err_ff;     // prefix error status, ST_OK when none
   logic                rsp_valid_ff;
   logic [47:0]         rsp_data_ff;
   logic                clear;
   logic                feeding;
   parse_result_type    pres;
   logic                past_prefix_ff;

   assign req_tready = (state_ff != S_SHIFT) && (state_ff != S_RESP);
   assign feeding    = (state_ff == S_SHIFT);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   // The bit parser is cleared only when its result is taken into the
   // response register, so a stalled response keeps the parsed fields.
   assign clear      = (state_ff == S_RESP) && (!rsp_valid_ff || rsp_tready);

   hsps_bit_parser #(.MAX_MB_DIM(MAX_MB_DIM), .POC_CYCLE_MAX(POC_CYCLE_MAX)) u_bits (
      .clock, .reset, .clear,
      .bit_valid(feeding && err_ff == ST_OK),
      .bit_value(shreg_ff[7]),
      .result(pres)
   );

   always_ff @(posedge clock) begin
      logic [STATUS_W-1:0] st;
      logic [47:0]         rdata;
      state_type           ns;
      if (reset) begin
         state_ff <= S_START; bitcnt_ff <= '0; last_ff <= 1'b0; err_ff <= ST_OK;
         rsp_valid_ff <= 1'b0; past_prefix_ff <= 1'b0;
      end else begin
         // In S_RESP the register is either reloaded or still waiting.
         if (rsp_valid_ff && rsp_tready && state_ff != S_RESP) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_SHIFT: begin
               shreg_ff  <= {shreg_ff[6:0], 1'b0};
               bitcnt_ff <= bitcnt_ff + 3'd1;
               if (bitcnt_ff == 3'd7) state_ff <= last_ff ? S_RESP : S_BITS;
            end
            S_RESP: begin
               // Results wait here only while the output register is full.
               if (!rsp_valid_ff || rsp_tready) begin
                  if (err_ff != ST_OK)          st = err_ff;
                  else if (pres.failed)         st = ST_BAD_POC;
                  else if (pres.done)           st = ST_OK;
                  else if (!past_prefix_ff)     st = ST_PREFIX;
                  else                          st = ST_TRUNCATED;
                  rdata = '0;
                  rdata[2:0] = st;
                  if (st == ST_OK) begin
                     rdata[10:3]  = pres.sps_id;
                     rdata[27:11] = {pres.mb_columns, 4'd0};
                     rdata[44:28] = {pres.mb_rows, 4'd0};
                  end
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= rdata;
                  state_ff <= S_START; err_ff <= ST_OK; past_prefix_ff <= 1'b0;
               end
            end
            default: begin
               if (req_tvalid) begin
                  last_ff <= req_tlast;
                  if (err_ff != ST_OK || pres.done || pres.failed) begin
                     if (req_tlast) state_ff <= S_RESP;
                  end else begin
                     ns = state_ff;
                     unique case (state_ff)
                        S_START:
                           if (req_tdata == 8'd0) ns = S_ZERO1;
                           else if (req_tdata[3:0] != 4'h7) err_ff <= ST_NOT_SPS;
                           else begin ns = S_BITS; past_prefix_ff <= 1'b1; end
                        S_ZERO1:
                           if (req_tdata == 8'd0) ns = S_ZERO2;
                           else if (req_tdata <= 8'd3) err_ff <= ST_PREFIX;
                           else err_ff <= ST_NOT_SPS;
                        S_ZERO2:
                           if (req_tdata == 8'd0) ns = S_ZERO3;
                           else err_ff <= ST_PREFIX;
                        S_ZERO3:
                           if (req_tdata == 8'd1) ns = S_NAL;
                           else err_ff <= ST_PREFIX;
                        S_NAL:
                           if (req_tdata[3:0] != 4'h7) err_ff <= ST_NOT_SPS;
                           else begin ns = S_BITS; past_prefix_ff <= 1'b1; end
                        default: begin
                           shreg_ff <= req_tdata; bitcnt_ff <= '0; ns = S_SHIFT;
                        end
                     endcase
                     if (req_tlast && state_ff != S_BITS) ns = S_RESP;
                     state_ff <= ns;
                  end
               end
            end
         endcase
      end
   end

   a_busy: assert property (@(posedge clock) disable iff (reset)
      feeding |-> !req_tready) else $error("request taken while shifting");
   a_resp_one: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESP && (!rsp_valid_ff || rsp_tready)) |=> rsp_tvalid)
      else $error("response lost");
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[2:0] <= ST_TRUNCATED) else $error("bad status");
endmodule

>>> rtl/hsps_bit_parser.sv
// Bit-serial SPS syntax parser: one bit per cycle while bit_valid is high, through a shared field unit.
// Depends on hsps_pkg.
module hsps_bit_parser #(
   parameter int unsigned MAX_MB_DIM    = 4096,
   parameter int unsigned POC_CYCLE_MAX = 256
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      clear,
   input  logic                      bit_valid,
   input  logic                      bit_value,
   output hsps_pkg::parse_result_type result
);
   import hsps_pkg::*;

   typedef enum logic [4:0] {
      PH_PLB, PH_ID, PH_CHROMA, PH_RCT, PH_BDL, PH_BDC, PH_BYPASS_MATRIX,
      PH_LIST_FLAG, PH_DELTA, PH_FRAMENUM, PH_POCTYPE, PH_LSB, PH_ALWAYS0,
      PH_NONREF, PH_TOPBOT, PH_CYCLE, PH_REFOFF, PH_NUMREF, PH_GAPS,
      PH_WIDTH, PH_HEIGHT, PH_IDLE
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [5:0]  bits_left_ff, bits_left_in;
   logic [5:0]  zero_run_ff, zero_run_in;
   logic [31:0] accum_ff, accum_in;
   logic [7:0]  profile_ff, profile_in;
   logic [2:0]  list_ff, list_in;
   logic [6:0]  scale_pos_ff, scale_pos_in;
   logic [7:0]  prev_scale_ff, prev_scale_in;
   logic [8:0]  cycle_left_ff, cycle_left_in;
   logic [7:0]  id_ff, id_in;
   logic [12:0] cols_ff, cols_in, rows_ff, rows_in;
   logic        done_ff, done_in, failed_ff, failed_in;

   logic        fin;
   logic [31:0] fval;
   logic [31:0] shifted;
   logic [7:0]  d8, upcoming;
   logic [8:0]  cyc_sat;
   logic [6:0]  list_size;

   function automatic logic [5:0] fixed_len(phase_type p);
      case (p)
         PH_PLB:           fixed_len = 6'd24;
         PH_BYPASS_MATRIX: fixed_len = 6'd2;
         PH_RCT, PH_LIST_FLAG, PH_ALWAYS0, PH_GAPS: fixed_len = 6'd1;
         default:          fixed_len = 6'd0;
      endcase
   endfunction

   function automatic logic [12:0] mb_count(logic [31:0] v);
      if (v >= 32'(MAX_MB_DIM)) mb_count = 13'(MAX_MB_DIM);
      else                      mb_count = 13'(v + 32'd1);
   endfunction

   always_comb begin
      phase_type nxt;
      phase_in = phase_ff;      bits_left_in = bits_left_ff; zero_run_in = zero_run_ff;
      accum_in = accum_ff;      profile_in = profile_ff;     list_in = list_ff;
      scale_pos_in = scale_pos_ff; prev_scale_in = prev_scale_ff;
      cycle_left_in = cycle_left_ff; id_in = id_ff; cols_in = cols_ff; rows_in = rows_ff;
      done_in = done_ff; failed_in = failed_ff;
      fin = 1'b0; fval = '0; nxt = phase_ff;
      shifted = {accum_ff[30:0], bit_value};
      d8 = fval[0] ? 8'(fval[8:1] + 8'd1) : 8'(-fval[8:1]);
      upcoming = '0; cyc_sat = '0;
      list_size = (list_ff < 3'd6) ? 7'd16 : 7'd64;
      if (bit_valid && !done_ff && !failed_ff && phase_ff != PH_IDLE) begin
         if (fixed_len(phase_ff) != 6'd0) begin
            accum_in = shifted;
            if (bits_left_ff <= 6'd1) begin fin = 1'b1; fval = shifted; end
            else bits_left_in = bits_left_ff - 6'd1;
         end else if (bits_left_ff != 6'd0) begin
            accum_in = shifted;
            bits_left_in = bits_left_ff - 6'd1;
            if (bits_left_ff == 6'd1) begin fin = 1'b1; fval = shifted - 32'd1; end
         end else if (bit_value) begin
            if (zero_run_ff == 6'd0) fin = 1'b1;
            else begin accum_in = 32'd1; bits_left_in = zero_run_ff; end
         end else begin
            zero_run_in = zero_run_ff + 6'd1;
            if (zero_run_ff >= 6'd31) begin fin = 1'b1; fval = '1; end
         end
      end
      d8 = fval[0] ? 8'(fval[8:1] + 8'd1) : 8'(8'd0 - fval[8:1]);
      upcoming = prev_scale_ff + d8;
      cyc_sat = (fval > 32'(POC_CYCLE_MAX)) ? 9'(POC_CYCLE_MAX) : fval[8:0];
      if (fin) begin
         unique case (phase_ff)
            PH_PLB: begin profile_in = fval[23:16]; nxt = PH_ID; end
            PH_ID: begin
               id_in = (fval > 32'd255) ? 8'd255 : fval[7:0];
               nxt = (profile_ff == 8'd100 || profile_ff == 8'd110 ||
                      profile_ff == 8'd122 || profile_ff == 8'd144)
                     ? PH_CHROMA : PH_FRAMENUM;
            end
            PH_CHROMA: nxt = (fval == 32'd3) ? PH_RCT : PH_BDL;
            PH_RCT:    nxt = PH_BDL;
            PH_BDL:    nxt = PH_BDC;
            PH_BDC:    nxt = PH_BYPASS_MATRIX;
            PH_BYPASS_MATRIX: begin
               if (fval[0]) begin list_in = '0; nxt = PH_LIST_FLAG; end
               else nxt = PH_FRAMENUM;
            end
            PH_LIST_FLAG: begin
               if (fval[0]) begin
                  scale_pos_in = '0; prev_scale_in = 8'd8; nxt = PH_DELTA;
               end else if (list_ff == 3'd7) nxt = PH_FRAMENUM;
               else begin list_in = list_ff + 3'd1; nxt = PH_LIST_FLAG; end
            end
            PH_DELTA: begin
               if (upcoming != 8'd0) prev_scale_in = upcoming;
               scale_pos_in = scale_pos_ff + 7'd1;
               if (upcoming == 8'd0 || scale_pos_in >= list_size) begin
                  if (list_ff == 3'd7) nxt = PH_FRAMENUM;
                  else begin list_in = list_ff + 3'd1; nxt = PH_LIST_FLAG; end
               end else nxt = PH_DELTA;
            end
            PH_FRAMENUM: nxt = PH_POCTYPE;
            PH_POCTYPE: begin
               if (fval == 32'd0)      nxt = PH_LSB;
               else if (fval == 32'd1) nxt = PH_ALWAYS0;
               else if (fval == 32'd2) nxt = PH_NUMREF;
               else begin failed_in = 1'b1; nxt = PH_IDLE; end
            end
            PH_LSB:     nxt = PH_NUMREF;
            PH_ALWAYS0: nxt = PH_NONREF;
            PH_NONREF:  nxt = PH_TOPBOT;
            PH_TOPBOT:  nxt = PH_CYCLE;
            PH_CYCLE: begin
               cycle_left_in = cyc_sat;
               nxt = (cyc_sat == 9'd0) ? PH_NUMREF : PH_REFOFF;
            end
            PH_REFOFF: begin
               cycle_left_in = cycle_left_ff - 9'd1;
               nxt = (cycle_left_ff <= 9'd1) ? PH_NUMREF : PH_REFOFF;
            end
            PH_NUMREF: nxt = PH_GAPS;
            PH_GAPS:   nxt = PH_WIDTH;
            PH_WIDTH:  begin cols_in = mb_count(fval); nxt = PH_HEIGHT; end
            PH_HEIGHT: begin rows_in = mb_count(fval); done_in = 1'b1; nxt = PH_IDLE; end
            default:   nxt = PH_IDLE;
         endcase
         phase_in = nxt;
         bits_left_in = fixed_len(nxt);
         zero_run_in = '0;
         accum_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         phase_ff <= PH_PLB; bits_left_ff <= 6'd24; zero_run_ff <= '0; accum_ff <= '0;
         profile_ff <= '0; list_ff <= '0; scale_pos_ff <= '0; prev_scale_ff <= 8'd8;
         cycle_left_ff <= '0; id_ff <= '0; cols_ff <= '0; rows_ff <= '0;
         done_ff <= 1'b0; failed_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in; bits_left_ff <= bits_left_in; zero_run_ff <= zero_run_in;
         accum_ff <= accum_in; profile_ff <= profile_in; list_ff <= list_in;
         scale_pos_ff <= scale_pos_in; prev_scale_ff <= prev_scale_in;
         cycle_left_ff <= cycle_left_in; id_ff <= id_in; cols_ff <= cols_in;
         rows_ff <= rows_in; done_ff <= done_in; failed_ff <= failed_in;
      end
   end

   assign result = '{done: done_ff, failed: failed_ff, sps_id: id_ff,
                     mb_columns: cols_ff, mb_rows: rows_ff};

   a_done_excl: assert property (@(posedge clock) disable iff (reset)
      !(done_ff && failed_ff)) else $error("done and failed together");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> phase_ff == PH_IDLE) else $error("done outside idle");
   a_cols_range: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (cols_ff != 13'd0 && rows_ff != 13'd0)) else $error("zero size");
endmodule
